>>> rtl/hash_bucket_insert_or_find_macros.svh
// Assertion macros for the hash bucket insert-or-find checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef HASH_BUCKET_INSERT_OR_FIND_MACROS_SVH
`define HASH_BUCKET_INSERT_OR_FIND_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HBIF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HBIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hbif_pkg.sv
// Shared constants and controller/datapath interface types for the
// hash bucket insert-or-find block. No dependencies.
package hbif_pkg;

    // Default table geometry
    localparam int DEF_BUCKETS  = 1024;
    localparam int DEF_WAYS     = 8;
    localparam int DEF_KEY_BITS = 64;

    // Fixed port widths
    localparam int HASH_W = 32;
    localparam int KEY_W  = 64;

    // Remainder unit: reciprocal multiply, then multiply and subtract
    localparam int DIV_CYCLES = 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;   // zero one bucket fill count
        logic capture;      // take in a new transfer
        logic div_step;     // advance the bucket remainder
        logic read;         // read fill count and bucket row
        logic resolve;      // compare, report and append
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;   // final bucket of the clearing pass
        logic need_div;     // bucket count is not a power of two
        logic div_last;     // final remainder step
    } t_status;

endpackage

>>> rtl/hbif_ctrl.sv
// Controller FSM for the hash bucket insert-or-find block.
// Depends on hbif_pkg for the command and status types.
module hbif_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  hbif_pkg::t_status i_status,
    output hbif_pkg::t_cmd    o_cmd
);
    import hbif_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_READ  = 5'b01000,
        S_CMP   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Accept a transfer when idle or while resolving the previous one
    assign busy   = !((r_state == S_IDLE) || (r_state == S_CMP));
    assign accept = start && !busy;

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.capture    = accept;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = i_status.need_div ? S_DIV : S_READ;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                o_cmd.resolve = 1'b1;
                if (accept) n_state = i_status.need_div ? S_DIV : S_READ;
                else        n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register, clearing pass runs after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

endmodule

>>> rtl/hbif_datapath.sv
// Datapath for the hash bucket insert-or-find block: bucket remainder
// unit, fill-count and entry memories, way compare and result registers.
// Depends on hbif_pkg.
module hbif_datapath #(
    parameter int BUCKETS  = hbif_pkg::DEF_BUCKETS,
    parameter int WAYS     = hbif_pkg::DEF_WAYS,
    parameter int KEY_BITS = hbif_pkg::DEF_KEY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hbif_pkg::t_cmd              i_cmd,
    output hbif_pkg::t_status           o_status,
    input  logic [hbif_pkg::HASH_W-1:0] i_hash_value,
    input  logic [hbif_pkg::KEY_W-1:0]  i_key,
    output logic                        o_done,
    output logic                        o_found,
    output logic [hbif_pkg::KEY_W-1:0]  o_stored_key,
    output logic                        o_bucket_full
);
    import hbif_pkg::*;

    localparam int  BIDX_W   = $clog2(BUCKETS);
    localparam int  FILL_W   = $clog2(WAYS + 1);
    localparam int  SLOT_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit  NEED_DIV = (BUCKETS & (BUCKETS - 1)) != 0;

    // Quotient by reciprocal: hash / BUCKETS = (hash * RECIP) >> RECIP_SH,
    // exact over the whole 32-bit hash range with RECIP rounded up
    localparam int  RECIP_SH = HASH_W + BIDX_W;
    localparam int  PROD_W   = 2 * HASH_W + 1;
    localparam logic [HASH_W:0] RECIP =
        (HASH_W + 1)'(((64'd1 << RECIP_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    // Captured transfer and remainder state
    logic [HASH_W-1:0]    r_hash;
    logic [KEY_BITS-1:0]  r_key;
    logic [HASH_W-1:0]    r_quot;
    logic [BIDX_W-1:0]    r_rem;
    logic [PROD_W-1:0]    prod;
    logic [HASH_W-1:0]    quot;
    logic [HASH_W-1:0]    rem_full;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [BIDX_W-1:0]    r_clr_idx;
    logic [BIDX_W-1:0]    bucket_idx;

    // Memories and registered read data
    logic [FILL_W-1:0]    r_fill_mem [BUCKETS];
    logic [KEY_BITS-1:0]  r_entries  [BUCKETS][WAYS];
    logic [FILL_W-1:0]    r_fill_q;
    logic [KEY_BITS-1:0]  r_row_q    [WAYS];

    // Compare results
    logic [WAYS-1:0]      hit;
    logic                 found;
    logic                 full;
    logic                 append;
    logic [SLOT_W-1:0]    slot;

    // Result registers
    logic                 r_done;
    logic                 r_found;
    logic                 r_full;
    logic [KEY_W-1:0]     r_stored;

    assign o_status.clear_last = (r_clr_idx == BIDX_W'(BUCKETS - 1));
    assign o_status.need_div   = NEED_DIV;
    assign o_status.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));

    // Power-of-two tables take the low hash bits, others the remainder
    assign bucket_idx = NEED_DIV ? r_rem : r_hash[BIDX_W-1:0];

    // First step forms the quotient, second step the remainder from it
    assign prod     = PROD_W'(r_hash) * PROD_W'(RECIP);
    assign quot     = HASH_W'(prod >> RECIP_SH);
    assign rem_full = r_hash - r_quot * HASH_W'(BUCKETS);

    // Capture the transfer and advance the remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hash <= i_hash_value;
            r_key  <= i_key[KEY_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_quot <= quot;
            r_rem  <= rem_full[BIDX_W-1:0];
        end
    end

    // Remainder step counter and clearing-pass index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.capture)       r_div_cnt <= '0;
            else if (i_cmd.div_step) r_div_cnt <= r_div_cnt + 1'b1;
            if (i_cmd.clear_step)    r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Compare every occupied way against the key
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit[w] = (FILL_W'(w) < r_fill_q) && (r_row_q[w] == r_key);
        end
    end

    assign found  = |hit;
    assign full   = !found && (r_fill_q == FILL_W'(WAYS));
    assign append = !found && !full;
    assign slot   = r_fill_q[SLOT_W-1:0];

    // Fill-count memory: clear, bump on append, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_fill_mem[r_clr_idx] <= '0;
        end else if (i_cmd.resolve && append) begin
            r_fill_mem[bucket_idx] <= r_fill_q + 1'b1;
        end
        if (i_cmd.read) r_fill_q <= r_fill_mem[bucket_idx];
    end

    // Entry memory: one row per bucket, write one slot on append
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && append) r_entries[bucket_idx][slot] <= r_key;
        if (i_cmd.read)              r_row_q <= r_entries[bucket_idx];
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= i_cmd.resolve;
    end

    // Result payload; a match means the stored key equals the key
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_found  <= found;
            r_full   <= full;
            r_stored <= found ? KEY_W'(r_key) : '0;
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_bucket_full = r_full;
    assign o_stored_key  = r_stored;

endmodule

>>> rtl/hash_bucket_insert_or_find.sv
// Hash bucket insert-or-find. Power-of-two BUCKETS: capture the transfer, then read
// fill count and bucket row, then compare and write back, setting the result strobe;
// a new transfer can be taken while the previous one resolves. Other BUCKETS add the
// quotient and remainder steps before the read. After reset a clearing pass zeroes
// one fill count per cycle, with busy high. Results cannot be stalled by the receiver.
module hash_bucket_insert_or_find #(
    parameter int BUCKETS  = hbif_pkg::DEF_BUCKETS,
    parameter int WAYS     = hbif_pkg::DEF_WAYS,
    parameter int KEY_BITS = hbif_pkg::DEF_KEY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [hbif_pkg::HASH_W-1:0] i_hash_value,
    input  logic [hbif_pkg::KEY_W-1:0]  i_key,
    output logic                        o_done,
    output logic                        o_found,
    output logic [hbif_pkg::KEY_W-1:0]  o_stored_key,
    output logic                        o_bucket_full
);
    import hbif_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence each transfer
    hbif_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Table storage, compare and results
    hbif_datapath #(
        .BUCKETS  (BUCKETS),
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_hash_value  (i_hash_value),
        .i_key         (i_key),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_stored_key  (o_stored_key),
        .o_bucket_full (o_bucket_full)
    );

endmodule

>>> rtl/hbif_checker.sv
// Port-level assertions for the hash bucket insert-or-find block, bound
// to the top level. Depends on hbif_pkg and the assertion macro header.
`include "hash_bucket_insert_or_find_macros.svh"

module hbif_port_checks (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic                        o_found,
    input logic [hbif_pkg::KEY_W-1:0]  o_stored_key,
    input logic                        o_bucket_full
);
    import hbif_pkg::*;

    // A key is either found or dropped, never both
    `HBIF_ASSERT_IMPL(a_found_xor_full, o_done, !(o_found && o_bucket_full), "found and full")

    // A miss returns zero as the stored key
    `HBIF_ASSERT_IMPL(a_miss_zero_key, o_done && !o_found, o_stored_key == '0, "miss with key")

    // No two results come back to back
    `HBIF_ASSERT_NEXT(a_done_spacing, o_done, !o_done, "back-to-back results")

    // Lookup runs after an accepted transfer
    `HBIF_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after transfer")

endmodule

bind hash_bucket_insert_or_find hbif_port_checks u_hbif_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_found       (o_found),
    .o_stored_key  (o_stored_key),
    .o_bucket_full (o_bucket_full)
);
